// ===== sv/thw_pkg.sv =====
package thw_pkg;

    localparam int unsigned OFFSET_BITS_DEF = 32;
    localparam int unsigned OFFSET_BITS_MAX = 48;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 33;
    localparam int unsigned NEXT_W   = 40;
    localparam int unsigned SIZE_W   = 36;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned OFF_W    = 32;
    localparam int unsigned IDX_W    = 9;

    // header byte offsets
    localparam logic [IDX_W-1:0] IDX_SIZE_FIRST = 9'd124;
    localparam logic [IDX_W-1:0] IDX_SIZE_LAST  = 9'd135;
    localparam logic [IDX_W-1:0] IDX_TYPEFLAG   = 9'd156;
    localparam logic [IDX_W-1:0] IDX_PREFIX     = 9'd345;
    localparam logic [IDX_W-1:0] IDX_BLOCK_END  = 9'd511;

    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [BYTE_W-1:0] CH_DIR   = 8'h35;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_DONE
    } t_phase;

    typedef enum logic {
        REC_ENTRY = 1'b0,
        REC_END   = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               is_dir;
        logic [SIZE_W-1:0]  size;
        logic [OFF_W-1:0]   offset;
        logic               has_data;
        logic               has_prefix;
        logic [CNT_W-1:0]   number;
        logic               last;
    } t_record;

    typedef struct packed {
        logic [1:0] count;
        t_record    rec0;
        t_record    rec1;
    } t_walk_out;

endpackage

// ===== sv/thw_in_if.sv =====
interface thw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

// ===== sv/thw_cfg_if.sv =====
interface thw_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== sv/thw_out_if.sv =====
interface thw_out_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic        entry_is_directory;
    logic [35:0] entry_size;
    logic [31:0] data_offset;
    logic        has_data;
    logic        has_prefix;
    logic [31:0] entry_number;
    logic        last_of_run;

    modport source (output valid, record_kind, entry_is_directory, entry_size, data_offset,
                    has_data, has_prefix, entry_number, last_of_run, input ready);
    modport sink   (input valid, record_kind, entry_is_directory, entry_size, data_offset,
                    has_data, has_prefix, entry_number, last_of_run, output ready);
endinterface

// ===== sv/thw_walker.sv =====
module thw_walker #(
    parameter int unsigned OFFSET_BITS = thw_pkg::OFFSET_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [thw_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_first_byte,
    input  logic                          i_last_byte,
    input  logic [thw_pkg::LEN_W-1:0]     i_archive_length,
    output thw_pkg::t_walk_out            o_walk
);
    import thw_pkg::*;

    localparam logic [OFFSET_BITS_MAX-1:0] OFF_LIM =
        (OFFSET_BITS_MAX'(1) << OFFSET_BITS) - OFFSET_BITS_MAX'(1);
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_hs, n_hs;
    logic [NEXT_W-1:0] r_next, n_next;
    t_phase            r_phase, n_phase;
    logic [SIZE_W-1:0] r_acc, n_acc;
    logic              r_stop, n_stop;
    logic              r_dir, n_dir;
    logic              r_pre, n_pre;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // first_byte restarts from the reset values
    logic [POS_W-1:0]  e_pos, e_hs;
    logic [NEXT_W-1:0] e_next;
    t_phase            e_phase;
    logic [SIZE_W-1:0] e_acc;
    logic              e_stop, e_dir, e_pre;
    logic [CNT_W-1:0]  e_cnt;

    logic              skip_done, in_header;
    logic [POS_W-1:0]  hs, idx;
    logic              idx_hi;
    logic [IDX_W-1:0]  idx_lo;
    logic              at_start, at_close, in_size, at_type, at_prefix;
    logic              is_octal, hdr_end, last_end;
    logic [POS_W:0]    doff_full;
    logic [OFFSET_BITS_MAX-1:0] doff_wide, doff_sat;
    logic [SIZE_W:0]   round_sum;
    t_phase            ph_after_hdr;
    t_record           rec_hdr, rec_last;

    assign e_pos   = i_first_byte ? '0 : r_pos;
    assign e_hs    = i_first_byte ? '0 : r_hs;
    assign e_next  = i_first_byte ? '0 : r_next;
    assign e_phase = i_first_byte ? PH_HEADER : r_phase;
    assign e_acc   = i_first_byte ? '0 : r_acc;
    assign e_stop  = i_first_byte ? 1'b0 : r_stop;
    assign e_dir   = i_first_byte ? 1'b0 : r_dir;
    assign e_pre   = i_first_byte ? 1'b0 : r_pre;
    assign e_cnt   = i_first_byte ? '0 : r_cnt;

    assign skip_done = (e_phase == PH_SKIP) && ({(NEXT_W-POS_W)'(0), e_pos} >= e_next);
    assign in_header = (e_phase == PH_HEADER) || skip_done;
    assign hs        = skip_done ? e_pos : e_hs;
    assign idx       = e_pos - hs;
    assign idx_hi    = (idx[POS_W-1:IDX_W] != '0);
    assign idx_lo    = idx[IDX_W-1:0];

    assign at_start  = in_header && !idx_hi && (idx_lo == '0);
    assign at_close  = in_header && !idx_hi && (idx_lo == IDX_BLOCK_END);
    assign in_size   = in_header && !idx_hi && (idx_lo >= IDX_SIZE_FIRST)
                       && (idx_lo <= IDX_SIZE_LAST);
    assign at_type   = in_header && !idx_hi && (idx_lo == IDX_TYPEFLAG);
    assign at_prefix = in_header && !idx_hi && (idx_lo == IDX_PREFIX);
    assign is_octal  = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_SEVEN);

    assign doff_full = {1'b0, hs} + (POS_W+1)'(512);
    assign hdr_end   = at_start && ((doff_full > {{(POS_W+1-LEN_W){1'b0}}, i_archive_length})
                                    || (i_data_byte == '0));

    assign doff_wide = {{(OFFSET_BITS_MAX-POS_W-1){1'b0}}, doff_full};
    assign doff_sat  = (doff_wide > OFF_LIM) ? OFF_LIM : doff_wide;
    assign round_sum = {1'b0, e_acc} + (SIZE_W+1)'(511);

    // walk phase
    always_comb begin
        if (hdr_end) begin
            ph_after_hdr = PH_DONE;
        end else if (at_close) begin
            ph_after_hdr = PH_SKIP;
        end else if (in_header) begin
            ph_after_hdr = PH_HEADER;
        end else begin
            ph_after_hdr = e_phase;
        end
        last_end = i_last_byte && (ph_after_hdr != PH_DONE);
        n_phase  = last_end ? PH_DONE : ph_after_hdr;
    end

    // header fields, counters and records
    always_comb begin
        n_hs   = hs;
        n_acc  = e_acc;
        n_stop = e_stop;
        n_dir  = e_dir;
        n_pre  = e_pre;
        n_cnt  = e_cnt;
        n_next = e_next;
        n_pos  = (e_pos == POS_MAX) ? e_pos : e_pos + POS_W'(1);

        if (at_start) begin
            n_acc  = '0;
            n_stop = 1'b0;
            n_dir  = 1'b0;
            n_pre  = 1'b0;
        end
        if (in_size && !e_stop) begin
            if (is_octal) begin
                n_acc = {e_acc[SIZE_W-4:0], i_data_byte[2:0]};
            end else begin
                n_stop = 1'b1;
            end
        end
        if (at_type) begin
            n_dir = (i_data_byte == CH_DIR);
        end
        if (at_prefix) begin
            n_pre = (i_data_byte != '0);
        end
        if (at_close) begin
            n_cnt  = (e_cnt == CNT_MAX) ? e_cnt : e_cnt + CNT_W'(1);
            // cannot exceed 40 bits, so no clamp is needed
            n_next = NEXT_W'(doff_full) + NEXT_W'({round_sum[SIZE_W:IDX_W], {IDX_W{1'b0}}});
        end

        rec_hdr = '0;
        if (at_close) begin
            rec_hdr.kind       = REC_ENTRY;
            rec_hdr.is_dir     = e_dir;
            rec_hdr.size       = e_acc;
            rec_hdr.has_data   = (e_acc != '0);
            rec_hdr.offset     = (e_acc != '0) ? doff_sat[OFF_W-1:0] : '0;
            rec_hdr.has_prefix = e_pre;
            rec_hdr.number     = e_cnt;
        end else begin
            rec_hdr.kind   = REC_END;
            rec_hdr.number = e_cnt;
        end
        rec_hdr.last = !last_end;

        rec_last        = '0;
        rec_last.kind   = REC_END;
        rec_last.number = n_cnt;
        rec_last.last   = 1'b1;

        o_walk = '0;
        if (hdr_end || at_close) begin
            o_walk.rec0  = rec_hdr;
            o_walk.rec1  = rec_last;
            o_walk.count = last_end ? 2'd2 : 2'd1;
        end else begin
            o_walk.rec0  = rec_last;
            o_walk.count = last_end ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hs    <= '0;
            r_next  <= '0;
            r_phase <= PH_HEADER;
            r_acc   <= '0;
            r_stop  <= 1'b0;
            r_dir   <= 1'b0;
            r_pre   <= 1'b0;
            r_cnt   <= '0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_hs    <= n_hs;
            r_next  <= n_next;
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_stop  <= n_stop;
            r_dir   <= n_dir;
            r_pre   <= n_pre;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/thw_result_fifo.sv =====
module thw_result_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  thw_pkg::t_walk_out                i_walk,
    input  logic                              i_pop,
    output thw_pkg::t_record                  o_head,
    output logic [thw_pkg::FIFO_CNT_W-1:0]    o_count
);
    import thw_pkg::*;

    t_record               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp, n_wp;
    logic [FIFO_PTR_W-1:0] r_rp, n_rp;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic [1:0]            push_n;

    assign push_n  = i_push ? i_walk.count : 2'd0;
    assign n_wp    = r_wp + FIFO_PTR_W'(push_n);
    assign n_rp    = r_rp + FIFO_PTR_W'(i_pop);
    assign n_count = r_count + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(i_pop);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wp] <= i_walk.rec0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wp + FIFO_PTR_W'(1)] <= i_walk.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/tar_header_walker_top.sv =====
// channel   modport  transfer carries
// i_in      sink     data_byte, first_byte, last_byte (one archive byte)
// i_cfg     sink     data (archive_length, 32 bits)
// o_out     source   one entry or end record
//
// one archive byte per cycle sustained while the queue has room; a byte is
// held in the input register, is decoded into the result queue, and its
// records show on o_out the cycle after that
// a byte yields zero, one or two records; the four-entry result queue takes a
// byte only with two slots free, so o_out stalls backpressure i_in
// synchronous active-low reset clears the walk state, the queue and
// archive_length; i_in and i_cfg hold ready low during reset, and i_cfg is
// ready in every cycle out of reset
module tar_header_walker_top #(
    parameter int unsigned OFFSET_BITS = thw_pkg::OFFSET_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    thw_in_if.sink           i_in,
    thw_cfg_if.sink          i_cfg,
    thw_out_if.source        o_out
);
    import thw_pkg::*;

    // input register
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_first;
    logic               r_in_last;

    logic [LEN_W-1:0]   r_archive_length;

    logic                  proc;
    logic                  in_ready;
    logic [FIFO_CNT_W-1:0] fifo_count;
    t_walk_out             walk;
    t_record               head;
    logic                  pop;

    // decode the held byte only when the queue can absorb two records
    assign proc     = r_in_valid && (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign in_ready = i_rst_n && (!r_in_valid || proc);
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && in_ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in_byte  <= i_in.data_byte;
            r_in_first <= i_in.first_byte;
            r_in_last  <= i_in.last_byte;
        end
    end

    // archive length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_archive_length <= '0;
        end else if (i_cfg.valid) begin
            r_archive_length <= i_cfg.data;
        end
    end

    // header walk: position tracking, octal size decode, record build
    thw_walker #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_walker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (proc),
        .i_data_byte      (r_in_byte),
        .i_first_byte     (r_in_first),
        .i_last_byte      (r_in_last),
        .i_archive_length (r_archive_length),
        .o_walk           (walk)
    );

    // result queue doubles as the output register
    assign pop = o_out.valid && o_out.ready;

    thw_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (proc),
        .i_walk  (walk),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (fifo_count)
    );

    assign o_out.valid              = (fifo_count != '0);
    assign o_out.record_kind        = head.kind;
    assign o_out.entry_is_directory = head.is_dir;
    assign o_out.entry_size         = head.size;
    assign o_out.data_offset        = head.offset;
    assign o_out.has_data           = head.has_data;
    assign o_out.has_prefix         = head.has_prefix;
    assign o_out.entry_number       = head.number;
    assign o_out.last_of_run        = head.last;

    // checks
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (walk.count == 2'd2) |->
            (walk.rec0.kind == REC_ENTRY) && (walk.rec1.kind == REC_END))
        else $error("two records from one byte not entry then end");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.record_kind == REC_END) |-> o_out.last_of_run)
        else $error("end record not last of its run");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.has_data |-> (o_out.data_offset == '0))
        else $error("data offset set without data");

endmodule
